// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both forms compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When the antecedent holds, the consequent holds in the same cycle.
`define BDP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define BDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define BDP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BDP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/bdp_pkg.sv -----
package bdp_pkg;

   // Default lane count and fixed datapath widths.
   localparam int BYTES_PER_ITEM = 8;
   localparam int LANE_W         = 12;
   localparam int SUM_W          = 18;
   localparam int FP_W           = 32;
   localparam int MAN_W          = 51;
   localparam int EXP_W          = 12;
   localparam int PC_W           = 4;

   localparam logic [PC_W-1:0] LAST_PAIR_STEP = 4'd11;
   localparam logic [PC_W-1:0] FINAL_STEP     = 4'd12;

   localparam logic [FP_W-1:0] FP_QNAN     = 32'h7fc0_0000;
   localparam logic [FP_W-1:0] FP_POS_ZERO = 32'h0000_0000;

   typedef enum logic [1:0] {
      FOP_MUL,
      FOP_ADD,
      FOP_CVT
   } fop_type;

   typedef enum logic [3:0] {
      SRC_T0, SRC_T1, SRC_T2, SRC_ACC, SRC_OFF,
      SRC_A_LO, SRC_A_HI, SRC_B_LO, SRC_B_HI,
      SRC_C_LO, SRC_C_HI, SRC_D_LO, SRC_D_HI,
      SRC_SUM0, SRC_SUM1
   } src_type;

   typedef enum logic [2:0] {
      DST_T0, DST_T1, DST_T2, DST_ACC, DST_OFF, DST_RES
   } dst_type;

   typedef struct packed {
      fop_type op;
      src_type src_a;
      src_type src_b;
      dst_type dst;
   } step_type;

   typedef struct packed {
      logic             start;
      fop_type          op;
      logic [FP_W-1:0]  a;
      logic [FP_W-1:0]  b;
      logic [SUM_W-1:0] ival;
   } fpu_req_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [FP_W-1:0] result;
   } fpu_rsp_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_WAIT
   } seq_state_type;

   typedef enum logic [2:0] {
      FPU_IDLE,
      FPU_LOAD,
      FPU_NORM,
      FPU_DENORM,
      FPU_ROUND
   } fpu_state_type;

   // Fixed order of float operations for one block pair, then the final sum.
   function automatic step_type prog_step(input logic [PC_W-1:0] pc);
      step_type s;
      unique case (pc)
         4'd0:    s = '{FOP_MUL, SRC_A_LO, SRC_B_LO, DST_T0};
         4'd1:    s = '{FOP_MUL, SRC_A_HI, SRC_B_HI, DST_T1};
         4'd2:    s = '{FOP_CVT, SRC_SUM0, SRC_T0,   DST_T2};
         4'd3:    s = '{FOP_MUL, SRC_T2,   SRC_T0,   DST_T2};
         4'd4:    s = '{FOP_ADD, SRC_ACC,  SRC_T2,   DST_ACC};
         4'd5:    s = '{FOP_CVT, SRC_SUM1, SRC_T0,   DST_T2};
         4'd6:    s = '{FOP_MUL, SRC_T2,   SRC_T1,   DST_T2};
         4'd7:    s = '{FOP_ADD, SRC_ACC,  SRC_T2,   DST_ACC};
         4'd8:    s = '{FOP_MUL, SRC_C_LO, SRC_D_LO, DST_T0};
         4'd9:    s = '{FOP_MUL, SRC_C_HI, SRC_D_HI, DST_T1};
         4'd10:   s = '{FOP_ADD, SRC_T0,   SRC_T1,   DST_T0};
         4'd11:   s = '{FOP_ADD, SRC_OFF,  SRC_T0,   DST_OFF};
         default: s = '{FOP_ADD, SRC_ACC,  SRC_OFF,  DST_RES};
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/core/bdp_lane.sv -----
module bdp_lane (
   input  logic [7:0]                     weight_byte,
   input  logic [7:0]                     act_first_byte,
   input  logic [7:0]                     act_second_byte,
   output logic [bdp_pkg::LANE_W-1:0]     prod_first,
   output logic [bdp_pkg::LANE_W-1:0]     prod_second
);

   logic signed [12:0] full_first;
   logic signed [12:0] full_second;

   // Unsigned nibble weight times signed activation; the result fits in twelve bits.
   assign full_first  = $signed({1'b0, weight_byte[3:0]}) * $signed(act_first_byte);
   assign full_second = $signed({1'b0, weight_byte[7:4]}) * $signed(act_second_byte);

   assign prod_first  = full_first[bdp_pkg::LANE_W-1:0];
   assign prod_second = full_second[bdp_pkg::LANE_W-1:0];

endmodule

// ----- rtl/core/bdp_merge.sv -----
module bdp_merge #(
   parameter int NUM_LANES = bdp_pkg::BYTES_PER_ITEM
) (
   input  logic [NUM_LANES-1:0][bdp_pkg::LANE_W-1:0] prod_first,
   input  logic [NUM_LANES-1:0][bdp_pkg::LANE_W-1:0] prod_second,
   output logic [bdp_pkg::SUM_W-1:0]                 dot_first,
   output logic [bdp_pkg::SUM_W-1:0]                 dot_second
);

   localparam int EXT_W = bdp_pkg::SUM_W - bdp_pkg::LANE_W;

   // Sign-extend each lane product and add the lanes up, wrapping at the sum width.
   always_comb begin
      dot_first  = '0;
      dot_second = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         dot_first  = dot_first
                    + {{EXT_W{prod_first[i][bdp_pkg::LANE_W-1]}}, prod_first[i]};
         dot_second = dot_second
                    + {{EXT_W{prod_second[i][bdp_pkg::LANE_W-1]}}, prod_second[i]};
      end
   end

endmodule

// ----- rtl/core/bdp_fpu.sv -----
module bdp_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  bdp_pkg::fpu_req_type  req,
   output bdp_pkg::fpu_rsp_type  rsp
);

   localparam int MW = bdp_pkg::MAN_W;
   localparam int EW = bdp_pkg::EXP_W;

   bdp_pkg::fpu_state_type state_ff, state_in;

   bdp_pkg::fop_type            op_ff;
   logic [bdp_pkg::FP_W-1:0]    a_ff, b_ff;
   logic [bdp_pkg::SUM_W-1:0]   ival_ff;
   logic                        sign_ff, sign_in;
   logic signed [EW-1:0]        exp_ff, exp_in;
   logic [MW-1:0]               man_ff, man_in;
   logic                        spec_ff;
   logic [bdp_pkg::FP_W-1:0]    specval_ff;

   // Operand decode and the first arithmetic step.
   logic [7:0]           ea, eb, eae, ebe, xe, ye, dexp;
   logic [23:0]          ma, mb, xm, ym;
   logic                 a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic                 a_big, xs, ys;
   logic [47:0]          prod;
   logic [MW-1:0]        mx, my0, my, addres;
   logic [bdp_pkg::SUM_W-1:0] imag;
   logic                 ld_sign, ld_spec;
   logic signed [EW-1:0] ld_exp;
   logic [MW-1:0]        ld_man;
   logic [bdp_pkg::FP_W-1:0] ld_specval;

   always_comb begin
      ea     = a_ff[30:23];
      eb     = b_ff[30:23];
      a_nan  = (ea == 8'hff) && (a_ff[22:0] != '0);
      b_nan  = (eb == 8'hff) && (b_ff[22:0] != '0);
      a_inf  = (ea == 8'hff) && (a_ff[22:0] == '0);
      b_inf  = (eb == 8'hff) && (b_ff[22:0] == '0);
      a_zero = (a_ff[30:0] == '0);
      b_zero = (b_ff[30:0] == '0);
      ma     = {(ea != 8'd0), a_ff[22:0]};
      mb     = {(eb != 8'd0), b_ff[22:0]};
      eae    = (ea == 8'd0) ? 8'd1 : ea;
      ebe    = (eb == 8'd0) ? 8'd1 : eb;
      prod   = ma * mb;

      // Larger magnitude goes first so that the difference never goes negative.
      a_big  = (a_ff[30:0] >= b_ff[30:0]);
      xs     = a_big ? a_ff[31] : b_ff[31];
      ys     = a_big ? b_ff[31] : a_ff[31];
      xe     = a_big ? eae : ebe;
      ye     = a_big ? ebe : eae;
      xm     = a_big ? ma : mb;
      ym     = a_big ? mb : ma;
      dexp   = xe - ye;
      mx     = {2'b00, xm, 25'd0};
      my0    = {2'b00, ym, 25'd0};
      if (dexp >= 8'd51) begin
         my = {{(MW-1){1'b0}}, (my0 != '0)};
      end else begin
         my = (my0 >> dexp)
            | {{(MW-1){1'b0}}, ((my0 & ~({MW{1'b1}} << dexp)) != '0)};
      end
      addres = (xs == ys) ? (mx + my) : (mx - my);

      imag = ival_ff[bdp_pkg::SUM_W-1] ? (~ival_ff + 1'b1) : ival_ff;

      ld_sign    = 1'b0;
      ld_exp     = '0;
      ld_man     = '0;
      ld_spec    = 1'b0;
      ld_specval = bdp_pkg::FP_POS_ZERO;
      unique case (op_ff)
         bdp_pkg::FOP_MUL: begin
            ld_sign = a_ff[31] ^ b_ff[31];
            ld_man  = {3'b000, prod};
            ld_exp  = $signed({4'b0000, eae}) + $signed({4'b0000, ebe}) - 12'sd300;
            if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
               ld_spec    = 1'b1;
               ld_specval = bdp_pkg::FP_QNAN;
            end else if (a_inf || b_inf) begin
               ld_spec    = 1'b1;
               ld_specval = {ld_sign, 8'hff, 23'd0};
            end else if (a_zero || b_zero) begin
               ld_spec    = 1'b1;
               ld_specval = {ld_sign, 31'd0};
            end
         end
         bdp_pkg::FOP_ADD: begin
            // An exact cancellation rounds to positive zero.
            ld_sign = (addres == '0) ? 1'b0 : xs;
            ld_man  = addres;
            ld_exp  = $signed({4'b0000, xe}) - 12'sd175;
            if (a_nan || b_nan || (a_inf && b_inf && (a_ff[31] != b_ff[31]))) begin
               ld_spec    = 1'b1;
               ld_specval = bdp_pkg::FP_QNAN;
            end else if (a_inf) begin
               ld_spec    = 1'b1;
               ld_specval = a_ff;
            end else if (b_inf) begin
               ld_spec    = 1'b1;
               ld_specval = b_ff;
            end else if (a_zero && b_zero) begin
               ld_spec    = 1'b1;
               ld_specval = {a_ff[31] & b_ff[31], 31'd0};
            end else if (a_zero) begin
               ld_spec    = 1'b1;
               ld_specval = b_ff;
            end else if (b_zero) begin
               ld_spec    = 1'b1;
               ld_specval = a_ff;
            end
         end
         default: begin
            ld_sign = ival_ff[bdp_pkg::SUM_W-1];
            ld_man  = {{(MW-bdp_pkg::SUM_W){1'b0}}, imag};
            ld_exp  = '0;
         end
      endcase
   end

   // Biased exponent of the value once the top mantissa bit is at bit fifty.
   logic signed [EW-1:0]      bexp;
   logic [7:0]                field;
   logic [30:0]               packed_mag;
   logic                      rnd;
   logic [bdp_pkg::FP_W-1:0]  round_res;

   always_comb begin
      bexp       = exp_ff + 12'sd177;
      field      = man_ff[MW-1] ? bexp[7:0] : 8'd0;
      packed_mag = {field, man_ff[49:27]};
      rnd        = man_ff[26] & ((man_ff[25:0] != '0) | man_ff[27]);
      if (spec_ff) begin
         round_res = specval_ff;
      end else if (man_ff == '0) begin
         round_res = {sign_ff, 31'd0};
      end else if (bexp >= 12'sd255) begin
         round_res = {sign_ff, 8'hff, 23'd0};
      end else begin
         round_res = {sign_ff, packed_mag + {30'd0, rnd}};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdp_pkg::FPU_IDLE:   if (req.start) state_in = bdp_pkg::FPU_LOAD;
         bdp_pkg::FPU_LOAD:   state_in = ld_spec ? bdp_pkg::FPU_ROUND : bdp_pkg::FPU_NORM;
         bdp_pkg::FPU_NORM: begin
            if (man_ff == '0)        state_in = bdp_pkg::FPU_ROUND;
            else if (man_ff[MW-1])   state_in = bdp_pkg::FPU_DENORM;
         end
         bdp_pkg::FPU_DENORM: if (bexp >= 12'sd1 || bexp < -12'sd24) begin
            state_in = bdp_pkg::FPU_ROUND;
         end
         default:             state_in = bdp_pkg::FPU_IDLE;
      endcase
   end

   // Mantissa and exponent updates for each state.
   always_comb begin
      sign_in = sign_ff;
      exp_in  = exp_ff;
      man_in  = man_ff;
      unique case (state_ff)
         bdp_pkg::FPU_LOAD: begin
            sign_in = ld_sign;
            exp_in  = ld_exp;
            man_in  = ld_man;
         end
         bdp_pkg::FPU_NORM: begin
            if (man_ff != '0 && !man_ff[MW-1]) begin
               if (man_ff[50:35] == '0) begin
                  man_in = man_ff << 16;
                  exp_in = exp_ff - 12'sd16;
               end else if (man_ff[50:47] == '0) begin
                  man_in = man_ff << 4;
                  exp_in = exp_ff - 12'sd4;
               end else begin
                  man_in = man_ff << 1;
                  exp_in = exp_ff - 12'sd1;
               end
            end
         end
         bdp_pkg::FPU_DENORM: begin
            // Far below the subnormal range the value rounds to a signed zero.
            if (bexp < -12'sd24) begin
               man_in = '0;
            end else if (bexp < 12'sd1) begin
               man_in = {1'b0, man_ff[MW-1:2], man_ff[1] | man_ff[0]};
               exp_in = exp_ff + 12'sd1;
            end
         end
         default: ;
      endcase
   end

   // Status towards the sequencer.
   always_comb begin
      rsp.busy   = (state_ff != bdp_pkg::FPU_IDLE);
      rsp.done   = (state_ff == bdp_pkg::FPU_ROUND);
      rsp.result = round_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdp_pkg::FPU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == bdp_pkg::FPU_IDLE && req.start) begin
         op_ff   <= req.op;
         a_ff    <= req.a;
         b_ff    <= req.b;
         ival_ff <= req.ival;
      end
      if (state_ff == bdp_pkg::FPU_LOAD) begin
         spec_ff    <= ld_spec;
         specval_ff <= ld_specval;
      end
      sign_ff <= sign_in;
      exp_ff  <= exp_in;
      man_ff  <= man_in;
   end

endmodule

// ----- rtl/core/int4_int8_block_dot_product.sv -----
// Block dot product of signed int8 activations with unsigned 4-bit weights. Each transfer
// on the req_ channel carries one packed weight byte per lane; all lanes multiply and a
// merge adder folds them into the two 18-bit block sums, so an item without req_pair_done
// or req_dot_done keeps req_ready high. An item with req_pair_done starts a sequence of
// twelve fp32 operations (multiplies, adds, int-to-float conversions, each rounded to
// nearest even) on one shared multi-cycle float unit, plus one more for req_dot_done; how
// long each operation runs depends on normalisation and on how far a tiny result must be
// shifted into the subnormal range, and such an item holds req_ready low until its
// sequence ends. An item with only req_dot_done runs the final add alone. The finished
// value sits in an output register; the next item is taken while it waits, and a new
// result waits only for that register to empty.
`include "assert_macros.svh"

module int4_int8_block_dot_product #(
   parameter int NUM_LANES = bdp_pkg::BYTES_PER_ITEM
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_weight_bytes,
   input  logic [63:0] req_act_first,
   input  logic [63:0] req_act_second,
   input  logic [63:0] req_act_scale_pair,
   input  logic [63:0] req_wt_scale_pair,
   input  logic [63:0] req_act_sum_pair,
   input  logic [63:0] req_wt_min_pair,
   input  logic        req_pair_done,
   input  logic        req_dot_done,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_dot_value
);

   localparam int SW = bdp_pkg::SUM_W;
   localparam int FW = bdp_pkg::FP_W;

   // Integer lanes and merge.
   logic [NUM_LANES-1:0][bdp_pkg::LANE_W-1:0] prod_first, prod_second;
   logic [SW-1:0] dot_first, dot_second;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      bdp_lane u_lane (
         .weight_byte     (req_weight_bytes[8*g +: 8]),
         .act_first_byte  (req_act_first[8*g +: 8]),
         .act_second_byte (req_act_second[8*g +: 8]),
         .prod_first      (prod_first[g]),
         .prod_second     (prod_second[g])
      );
   end

   bdp_merge #(.NUM_LANES(NUM_LANES)) u_merge (
      .prod_first  (prod_first),
      .prod_second (prod_second),
      .dot_first   (dot_first),
      .dot_second  (dot_second)
   );

   // Sequencer state and stored operands.
   bdp_pkg::seq_state_type state_ff, state_in;
   logic [bdp_pkg::PC_W-1:0] pc_ff;
   logic                     dot_ff;
   logic [SW-1:0]            sum0_ff, sum1_ff, sum0_in, sum1_in;
   logic [FW-1:0]            acc_ff, off_ff, t0_ff, t1_ff, t2_ff;
   logic [63:0]              a_ff, b_ff, c_ff, d_ff;
   logic                     rsp_valid_ff;
   logic [FW-1:0]            rsp_value_ff;

   bdp_pkg::step_type    step;
   bdp_pkg::fpu_req_type fpu_req;
   bdp_pkg::fpu_rsp_type fpu_rsp;
   logic                 accept, issue, write_back, emit, seq_end;
   logic [FW-1:0]        canon_res;

   function automatic logic [FW-1:0] pick(input bdp_pkg::src_type s,
                                          input logic [FW-1:0] t0, t1, t2, acc, off,
                                          input logic [63:0] a, b, c, d);
      logic [FW-1:0] v;
      unique case (s)
         bdp_pkg::SRC_T0:   v = t0;
         bdp_pkg::SRC_T1:   v = t1;
         bdp_pkg::SRC_T2:   v = t2;
         bdp_pkg::SRC_ACC:  v = acc;
         bdp_pkg::SRC_OFF:  v = off;
         bdp_pkg::SRC_A_LO: v = a[31:0];
         bdp_pkg::SRC_A_HI: v = a[63:32];
         bdp_pkg::SRC_B_LO: v = b[31:0];
         bdp_pkg::SRC_B_HI: v = b[63:32];
         bdp_pkg::SRC_C_LO: v = c[31:0];
         bdp_pkg::SRC_C_HI: v = c[63:32];
         bdp_pkg::SRC_D_LO: v = d[31:0];
         bdp_pkg::SRC_D_HI: v = d[63:32];
         default:           v = bdp_pkg::FP_POS_ZERO;
      endcase
      return v;
   endfunction

   assign step = bdp_pkg::prog_step(pc_ff);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdp_pkg::SEQ_IDLE: begin
            if (req_valid && (req_pair_done || req_dot_done)) begin
               state_in = bdp_pkg::SEQ_ISSUE;
            end
         end
         bdp_pkg::SEQ_ISSUE: begin
            if (!(step.dst == bdp_pkg::DST_RES && rsp_valid_ff)) begin
               state_in = bdp_pkg::SEQ_WAIT;
            end
         end
         default: begin
            if (fpu_rsp.done) begin
               if (step.dst == bdp_pkg::DST_RES ||
                   (pc_ff == bdp_pkg::LAST_PAIR_STEP && !dot_ff)) begin
                  state_in = bdp_pkg::SEQ_IDLE;
               end else begin
                  state_in = bdp_pkg::SEQ_ISSUE;
               end
            end
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = (state_ff == bdp_pkg::SEQ_IDLE);
      accept     = req_valid && req_ready;
      issue      = (state_ff == bdp_pkg::SEQ_ISSUE) &&
                   !(step.dst == bdp_pkg::DST_RES && rsp_valid_ff);
      write_back = (state_ff == bdp_pkg::SEQ_WAIT) && fpu_rsp.done;
      emit       = write_back && (step.dst == bdp_pkg::DST_RES);
      seq_end    = write_back && (step.dst == bdp_pkg::DST_RES ||
                   (pc_ff == bdp_pkg::LAST_PAIR_STEP && !dot_ff));
      fpu_req.start = issue;
      fpu_req.op    = step.op;
      fpu_req.a     = pick(step.src_a, t0_ff, t1_ff, t2_ff, acc_ff, off_ff,
                           a_ff, b_ff, c_ff, d_ff);
      fpu_req.b     = pick(step.src_b, t0_ff, t1_ff, t2_ff, acc_ff, off_ff,
                           a_ff, b_ff, c_ff, d_ff);
      fpu_req.ival  = (step.src_a == bdp_pkg::SRC_SUM1) ? sum1_ff : sum0_ff;
   end

   bdp_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   // Any NaN leaves as the canonical quiet NaN.
   assign canon_res = ((fpu_rsp.result[30:23] == 8'hff) && (fpu_rsp.result[22:0] != '0))
                    ? bdp_pkg::FP_QNAN : fpu_rsp.result;

   // Block sums: add the merged lanes on each transfer, clear when a sequence ends.
   always_comb begin
      sum0_in = sum0_ff;
      sum1_in = sum1_ff;
      if (accept) begin
         sum0_in = sum0_ff + dot_first;
         sum1_in = sum1_ff + dot_second;
      end else if (seq_end) begin
         sum0_in = '0;
         sum1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdp_pkg::SEQ_IDLE;
         pc_ff        <= '0;
         dot_ff       <= 1'b0;
         sum0_ff      <= '0;
         sum1_ff      <= '0;
         acc_ff       <= bdp_pkg::FP_POS_ZERO;
         off_ff       <= bdp_pkg::FP_POS_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum0_ff  <= sum0_in;
         sum1_ff  <= sum1_in;
         if (accept) begin
            dot_ff <= req_dot_done;
            pc_ff  <= req_pair_done ? '0 : bdp_pkg::FINAL_STEP;
         end else if (write_back) begin
            pc_ff <= pc_ff + 1'b1;
         end
         if (write_back) begin
            unique case (step.dst)
               bdp_pkg::DST_ACC: acc_ff <= fpu_rsp.result;
               bdp_pkg::DST_OFF: off_ff <= fpu_rsp.result;
               default: ;
            endcase
         end
         if (emit) begin
            acc_ff <= bdp_pkg::FP_POS_ZERO;
            off_ff <= bdp_pkg::FP_POS_ZERO;
         end
         // Output register: cleared on transfer, loaded when a result is ready.
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept && req_pair_done) begin
         a_ff <= req_act_scale_pair;
         b_ff <= req_wt_scale_pair;
         c_ff <= req_act_sum_pair;
         d_ff <= req_wt_min_pair;
      end
      if (write_back) begin
         unique case (step.dst)
            bdp_pkg::DST_T0: t0_ff <= fpu_rsp.result;
            bdp_pkg::DST_T1: t1_ff <= fpu_rsp.result;
            bdp_pkg::DST_T2: t2_ff <= fpu_rsp.result;
            default: ;
         endcase
      end
      if (emit) begin
         rsp_value_ff <= canon_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dot_value = rsp_value_ff;

   // A new result is only written into an empty output register.
   `BDP_ASSERT_IMPLY(a_emit_empty, clock, reset, emit, !rsp_valid_ff)
   // The float unit only finishes while the sequencer waits for it.
   `BDP_ASSERT_IMPLY(a_done_in_wait, clock, reset, fpu_rsp.done,
                     state_ff == bdp_pkg::SEQ_WAIT)
   // An item that closes a block pair blocks the input in the next cycle.
   `BDP_ASSERT_NEXT(a_pair_blocks, clock, reset, accept && req_pair_done, !req_ready)
   // No operation is issued while the float unit is still busy.
   `BDP_ASSERT_IMPLY(a_issue_free, clock, reset, issue, !fpu_rsp.busy)

endmodule
